FILE: design/quadratic_root_solver_unit_defines.svh
// ---------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared concurrent check helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

`ifndef SYNTH

// check that holds in the same cycle
`define QRS_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// check that holds in the cycle after the antecedent
`define QRS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define QRS_ASSERT_SAME(lbl, pre, post, msg)
`define QRS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

FILE: design/qrs_pkg.sv
// ---------------------------------------------------------------------------
// qrs_pkg
// shared types and constants of the quadratic root solver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrs_pkg;

   // tolerance register
   localparam int TOL_BITS = 16;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;

   // root classification
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_ONE  = 2'd1,
      KIND_TWO  = 2'd2,
      KIND_INF  = 2'd3
   } kind_type;

   // per stage control carried down the cell chains
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } ctl_type;

endpackage

FILE: design/qrs_if.sv
// ---------------------------------------------------------------------------
// qrs channel interfaces
// coefficient, result and tolerance write channels with valid and ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qrs_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] coef_a;
   logic signed [WORD_BITS-1:0] coef_b;
   logic signed [WORD_BITS-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c,
                   input ready);
   modport sink   (input valid, input coef_a, input coef_b, input coef_c,
                   output ready);
endinterface

interface qrs_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  root_kind;
   logic signed [WORD_BITS-1:0] root_first;
   logic signed [WORD_BITS-1:0] root_second;
   logic                        overflow;

   modport source (output valid, output root_kind, output root_first,
                   output root_second, output overflow, input ready);
   modport sink   (input valid, input root_kind, input root_first,
                   input root_second, input overflow, output ready);
endinterface

interface qrs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [qrs_pkg::TOL_BITS-1:0]  zero_tolerance;

   modport source (output valid, output zero_tolerance, input ready);
   modport sink   (input valid, input zero_tolerance, output ready);
endinterface

FILE: design/qrs_front.sv
// ---------------------------------------------------------------------------
// qrs_front
// magnitudes, products, discriminant and case split ahead of the cell chains
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_front #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             take,
   input  logic signed [WORD_BITS-1:0]      coef_a,
   input  logic signed [WORD_BITS-1:0]      coef_b,
   input  logic signed [WORD_BITS-1:0]      coef_c,
   input  logic [qrs_pkg::TOL_BITS-1:0]     tol,
   output qrs_pkg::ctl_type                 ctl_o,
   output logic signed [WORD_BITS:0]        numer_o,
   output logic [WORD_BITS:0]               denom_o,
   output logic                             denom_neg_o,
   output logic [2*WORD_BITS+1:0]           rad_o
);
   import qrs_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int MW   = 2 * WORD_BITS;
   localparam int DW   = 2 * WORD_BITS + 1;
   localparam int RADW = 2 * WORD_BITS + 2;
   localparam int TW   = TOL_BITS + FRAC_BITS;
   localparam int CW   = (DW > TW) ? DW : TW;

   // stage a: magnitudes and flags
   logic         va_ff;
   logic [W-1:0] am_a_ff, bm_a_ff, cm_a_ff;
   logic         an_a_ff, bn_a_ff, cn_a_ff, bnz_a_ff, cnz_a_ff;
   logic [W-1:0] am_in, bm_in, cm_in;

   assign am_in = coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
   assign bm_in = coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
   assign cm_in = coef_c[W-1] ? W'(-coef_c) : W'(coef_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         am_a_ff  <= am_in;
         bm_a_ff  <= bm_in;
         cm_a_ff  <= cm_in;
         an_a_ff  <= coef_a[W-1];
         bn_a_ff  <= coef_b[W-1];
         cn_a_ff  <= coef_c[W-1];
         bnz_a_ff <= |coef_b;
         cnz_a_ff <= |coef_c;
      end
   end

   // stage b: b squared, a times c, linear test
   logic          vb_ff;
   logic [MW-1:0] bb_b_ff, ac_b_ff, bb_in, ac_in;
   logic [W-1:0]  am_b_ff, bm_b_ff, cm_b_ff;
   logic          an_b_ff, bn_b_ff, cn_b_ff, bnz_b_ff, cnz_b_ff, lin_b_ff, lin_in;

   assign bb_in  = MW'(bm_a_ff) * MW'(bm_a_ff);
   assign ac_in  = MW'(am_a_ff) * MW'(cm_a_ff);
   assign lin_in = am_a_ff <= W'(tol);

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bb_b_ff  <= bb_in;
         ac_b_ff  <= ac_in;
         lin_b_ff <= lin_in;
         am_b_ff  <= am_a_ff;
         bm_b_ff  <= bm_a_ff;
         cm_b_ff  <= cm_a_ff;
         an_b_ff  <= an_a_ff;
         bn_b_ff  <= bn_a_ff;
         cn_b_ff  <= cn_a_ff;
         bnz_b_ff <= bnz_a_ff;
         cnz_b_ff <= cnz_a_ff;
      end
   end

   // stage c: discriminant magnitude and sign
   logic            vc_ff;
   logic [MW+1:0]   bbx, ac4, dsum, ddif;
   logic            acn;
   logic [DW-1:0]   dsc_c_ff, dsc_in;
   logic            dneg_c_ff, dneg_in;
   logic [W-1:0]    am_c_ff, bm_c_ff, cm_c_ff;
   logic            an_c_ff, bn_c_ff, cn_c_ff, bnz_c_ff, cnz_c_ff, lin_c_ff;

   always_comb begin
      bbx     = (MW+2)'(bb_b_ff);
      ac4     = {ac_b_ff, 2'b00};
      acn     = (an_b_ff ^ cn_b_ff) && cnz_b_ff;
      dsum    = bbx + ac4;
      ddif    = bbx - ac4;
      dsc_in  = acn ? DW'(dsum) : DW'(ddif);
      dneg_in = !acn && (bbx < ac4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsc_c_ff  <= dsc_in;
         dneg_c_ff <= dneg_in;
         lin_c_ff  <= lin_b_ff;
         am_c_ff   <= am_b_ff;
         bm_c_ff   <= bm_b_ff;
         cm_c_ff   <= cm_b_ff;
         an_c_ff   <= an_b_ff;
         bn_c_ff   <= bn_b_ff;
         cn_c_ff   <= cn_b_ff;
         bnz_c_ff  <= bnz_b_ff;
         cnz_c_ff  <= cnz_b_ff;
      end
   end

   // stage d: classify and pick numerator, denominator and radicand
   ctl_type          ctl_ff;
   kind_type         kind_in;
   logic signed [W:0] numer_ff, numer_in, negb, negc;
   logic [W:0]       denom_ff, denom_in;
   logic             dn_ff, dn_in, near;
   logic [RADW-1:0]  rad_ff, rad_in;
   logic [CW-1:0]    tolx;

   always_comb begin
      tolx     = CW'({tol, {FRAC_BITS{1'b0}}});
      near     = CW'(dsc_c_ff) <= tolx;
      negb     = bn_c_ff ? signed'({1'b0, bm_c_ff}) : -signed'({1'b0, bm_c_ff});
      negc     = cn_c_ff ? signed'({1'b0, cm_c_ff}) : -signed'({1'b0, cm_c_ff});
      kind_in  = KIND_NONE;
      numer_in = negb;
      denom_in = {am_c_ff, 1'b0};
      dn_in    = an_c_ff;
      rad_in   = '0;
      if (lin_c_ff) begin
         if (bnz_c_ff) begin
            kind_in  = KIND_ONE;
            numer_in = negc;
            denom_in = {1'b0, bm_c_ff};
            dn_in    = bn_c_ff;
         end else if (cnz_c_ff) begin
            kind_in = KIND_NONE;
         end else begin
            kind_in = KIND_INF;
         end
      end else if (dneg_c_ff) begin
         kind_in = KIND_NONE;
      end else if (near) begin
         kind_in = KIND_ONE;
      end else begin
         kind_in = KIND_TWO;
         rad_in  = RADW'(dsc_c_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff.valid <= vc_ff;
         ctl_ff.kind  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         numer_ff <= numer_in;
         denom_ff <= denom_in;
         dn_ff    <= dn_in;
         rad_ff   <= rad_in;
      end
   end

   assign ctl_o       = ctl_ff;
   assign numer_o     = numer_ff;
   assign denom_o     = denom_ff;
   assign denom_neg_o = dn_ff;
   assign rad_o       = rad_ff;

endmodule

FILE: design/qrs_sqrt_cell.sv
// ---------------------------------------------------------------------------
// qrs_sqrt_cell
// one digit of a restoring square root, two radicand bits per cell
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
   parameter int WORD_BITS = 32,
   parameter int SIDE_BITS = 67
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  qrs_pkg::ctl_type         ctl_i,
   input  logic [WORD_BITS+3:0]     rem_i,
   input  logic [WORD_BITS:0]       root_i,
   input  logic [2*WORD_BITS+1:0]   rad_i,
   input  logic [SIDE_BITS-1:0]     side_i,
   output qrs_pkg::ctl_type         ctl_o,
   output logic [WORD_BITS+3:0]     rem_o,
   output logic [WORD_BITS:0]       root_o,
   output logic [2*WORD_BITS+1:0]   rad_o,
   output logic [SIDE_BITS-1:0]     side_o
);
   import qrs_pkg::*;

   localparam int RW   = WORD_BITS + 4;
   localparam int SQ   = WORD_BITS + 1;
   localparam int RADW = 2 * WORD_BITS + 2;

   ctl_type          ctl_ff;
   logic [RW-1:0]    rem_ff, rem_in, trial, sub;
   logic [SQ-1:0]    root_ff, root_in;
   logic [RADW-1:0]  rad_ff, rad_in;
   logic [SIDE_BITS-1:0] side_ff;
   logic             ge;

   // trial subtract of 4*root+1 from the shifted remainder
   always_comb begin
      trial   = {rem_i[RW-3:0], rad_i[RADW-1 -: 2]};
      sub     = {1'b0, root_i, 2'b01};
      ge      = trial >= sub;
      rem_in  = ge ? (trial - sub) : trial;
      root_in = {root_i[SQ-2:0], ge};
      rad_in  = {rad_i[RADW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= side_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign rad_o  = rad_ff;
   assign side_o = side_ff;

endmodule

FILE: design/qrs_div_cell.sv
// ---------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of a restoring division, two root lanes side by side
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrs_div_cell #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  qrs_pkg::ctl_type                   ctl_i,
   input  logic [WORD_BITS:0]                 den_i,
   input  logic [1:0]                         sg_i,
   input  logic [WORD_BITS+FRAC_BITS+1:0]     numq_i [2],
   input  logic [WORD_BITS+1:0]               rem_i  [2],
   output qrs_pkg::ctl_type                   ctl_o,
   output logic [WORD_BITS:0]                 den_o,
   output logic [1:0]                         sg_o,
   output logic [WORD_BITS+FRAC_BITS+1:0]     numq_o [2],
   output logic [WORD_BITS+1:0]               rem_o  [2]
);
   import qrs_pkg::*;

   localparam int NB   = WORD_BITS + 2 + FRAC_BITS;
   localparam int REMW = WORD_BITS + 2;

   ctl_type          ctl_ff;
   logic [WORD_BITS:0] den_ff;
   logic [1:0]       sg_ff;
   logic [NB-1:0]    numq_ff [2];
   logic [NB-1:0]    numq_in [2];
   logic [REMW-1:0]  rem_ff  [2];
   logic [REMW-1:0]  rem_in  [2];
   logic [REMW-1:0]  trial   [2];
   logic [REMW-1:0]  dext;
   logic [1:0]       ge;

   // shift in the next numerator bit and try the subtract, per lane
   always_comb begin
      dext = REMW'(den_i);
      for (int l = 0; l < 2; l++) begin
         trial[l]   = {rem_i[l][REMW-2:0], numq_i[l][NB-1]};
         ge[l]      = trial[l] >= dext;
         rem_in[l]  = ge[l] ? (trial[l] - dext) : trial[l];
         numq_in[l] = {numq_i[l][NB-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= den_i;
         sg_ff   <= sg_i;
         numq_ff <= numq_in;
         rem_ff  <= rem_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign den_o  = den_ff;
   assign sg_o   = sg_ff;
   assign numq_o = numq_ff;
   assign rem_o  = rem_ff;

endmodule

FILE: design/quadratic_root_solver_unit.sv
// ---------------------------------------------------------------------------
// quadratic_root_solver_unit
// real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients
// ---------------------------------------------------------------------------
// req_bus carries one coefficient set per beat (coef_a, coef_b, coef_c),
// rsp_bus returns one result beat per set: root_kind, root_first,
// root_second and overflow, in the order the sets were taken.
// csr_bus writes zero_tolerance; write it only while the unit is empty.
// The pipeline has four front stages, a chain of WORD_BITS+1 square root
// cells, one numerator stage, WORD_BITS+FRAC_BITS+2 divider cells and the
// output register. The cell chains resolve one bit per cell, so a new set
// is accepted every cycle while req_bus.ready is high.
// Reset empties the pipeline and sets zero_tolerance to 66.
// When rsp_bus stalls, the pipeline keeps moving until a finished result
// reaches the last divider cell behind the held output beat; only then
// does the whole chain freeze and req_bus.ready drop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   qrs_req_if.sink     req_bus,
   qrs_rsp_if.source   rsp_bus,
   qrs_csr_if.sink     csr_bus
);
   import qrs_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int SQ   = WORD_BITS + 1;
   localparam int RW   = WORD_BITS + 4;
   localparam int RADW = 2 * WORD_BITS + 2;
   localparam int SIDE = 2 * WORD_BITS + 3;
   localparam int NMW  = WORD_BITS + 2;
   localparam int NB   = WORD_BITS + 2 + FRAC_BITS;
   localparam int REMW = WORD_BITS + 2;
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   // tolerance register
   logic [TOL_BITS-1:0] tol_ff, tol_in;

   assign csr_bus.ready = 1'b1;
   assign tol_in = csr_bus.valid ? csr_bus.zero_tolerance : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // chain advance: hold only when the last cell and the output both wait
   ctl_type dv_ctl [NB+1];
   logic    out_valid_ff, out_valid_in;
   logic    adv, take;

   assign adv           = !(dv_ctl[NB].valid && out_valid_ff && !rsp_bus.ready);
   assign req_bus.ready = adv;
   assign take          = req_bus.valid && adv;

   // front stages
   ctl_type           fr_ctl;
   logic signed [W:0] fr_numer;
   logic [W:0]        fr_denom;
   logic              fr_dneg;
   logic [RADW-1:0]   fr_rad;

   qrs_front #(
      .WORD_BITS (W),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .take        (take),
      .coef_a      (req_bus.coef_a),
      .coef_b      (req_bus.coef_b),
      .coef_c      (req_bus.coef_c),
      .tol         (tol_ff),
      .ctl_o       (fr_ctl),
      .numer_o     (fr_numer),
      .denom_o     (fr_denom),
      .denom_neg_o (fr_dneg),
      .rad_o       (fr_rad)
   );

   // square root chain
   ctl_type         sq_ctl  [SQ+1];
   logic [RW-1:0]   sq_rem  [SQ+1];
   logic [SQ-1:0]   sq_root [SQ+1];
   logic [RADW-1:0] sq_rad  [SQ+1];
   logic [SIDE-1:0] sq_side [SQ+1];

   assign sq_ctl[0]  = fr_ctl;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = fr_rad;
   assign sq_side[0] = {fr_numer, fr_denom, fr_dneg};

   for (genvar i = 0; i < SQ; i++) begin : g_sq
      qrs_sqrt_cell #(
         .WORD_BITS (W),
         .SIDE_BITS (SIDE)
      ) u_sq (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (sq_ctl[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .rad_i  (sq_rad[i]),
         .side_i (sq_side[i]),
         .ctl_o  (sq_ctl[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .rad_o  (sq_rad[i+1]),
         .side_o (sq_side[i+1])
      );
   end

   // numerator stage: -b plus and minus the root, split into sign and size
   ctl_type             e_ctl_ff;
   logic [NMW-1:0]      e_num_ff [2];
   logic [NMW-1:0]      e_num_in [2];
   logic [1:0]          e_sg_ff, e_sg_in;
   logic [W:0]          e_den_ff, e_den;
   logic signed [W:0]   e_nb;
   logic                e_dn;
   logic signed [W+2:0] e_nbx, e_sx, e_n1, e_n2;

   always_comb begin
      e_nb        = signed'(sq_side[SQ][SIDE-1 -: W+1]);
      e_den       = sq_side[SQ][W+1:1];
      e_dn        = sq_side[SQ][0];
      e_nbx       = (W+3)'(e_nb);
      e_sx        = signed'({2'b00, sq_root[SQ]});
      e_n1        = e_nbx + e_sx;
      e_n2        = e_nbx - e_sx;
      e_num_in[0] = e_n1[W+2] ? NMW'(-e_n1) : NMW'(e_n1);
      e_num_in[1] = e_n2[W+2] ? NMW'(-e_n2) : NMW'(e_n2);
      e_sg_in     = {e_n2[W+2] ^ e_dn, e_n1[W+2] ^ e_dn};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctl_ff <= '0;
      end else if (adv) begin
         e_ctl_ff <= sq_ctl[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_num_ff <= e_num_in;
         e_sg_ff  <= e_sg_in;
         e_den_ff <= e_den;
      end
   end

   // divider chain
   logic [W:0]      dv_den  [NB+1];
   logic [1:0]      dv_sg   [NB+1];
   logic [NB-1:0]   dv_numq [NB+1][2];
   logic [REMW-1:0] dv_rem  [NB+1][2];

   assign dv_ctl[0]     = e_ctl_ff;
   assign dv_den[0]     = e_den_ff;
   assign dv_sg[0]      = e_sg_ff;
   assign dv_numq[0][0] = {e_num_ff[0], {FRAC_BITS{1'b0}}};
   assign dv_numq[0][1] = {e_num_ff[1], {FRAC_BITS{1'b0}}};
   assign dv_rem[0][0]  = '0;
   assign dv_rem[0][1]  = '0;

   for (genvar i = 0; i < NB; i++) begin : g_dv
      qrs_div_cell #(
         .WORD_BITS (W),
         .FRAC_BITS (FRAC_BITS)
      ) u_dv (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (dv_ctl[i]),
         .den_i  (dv_den[i]),
         .sg_i   (dv_sg[i]),
         .numq_i (dv_numq[i]),
         .rem_i  (dv_rem[i]),
         .ctl_o  (dv_ctl[i+1]),
         .den_o  (dv_den[i+1]),
         .sg_o   (dv_sg[i+1]),
         .numq_o (dv_numq[i+1]),
         .rem_o  (dv_rem[i+1])
      );
   end

   // saturate to the word range and build the result beat
   logic [NB-1:0] sat_lim [2];
   logic [W-1:0]  sat_mag [2];
   logic [W-1:0]  sat_val [2];
   logic [1:0]    sat_neg, sat_over;
   logic          has_root;
   kind_type      out_kind_ff, out_kind_in;
   logic [W-1:0]  out_first_ff, out_first_in, out_second_ff, out_second_in;
   logic          out_ovf_ff, out_ovf_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         sat_neg[l]  = dv_sg[NB][l] && (|dv_numq[NB][l]);
         sat_lim[l]  = sat_neg[l] ? NB'(SAT_MIN) : NB'(SAT_MAX);
         sat_over[l] = dv_numq[NB][l] > sat_lim[l];
         sat_mag[l]  = sat_over[l] ? sat_lim[l][W-1:0] : dv_numq[NB][l][W-1:0];
         sat_val[l]  = sat_neg[l] ? (-sat_mag[l]) : sat_mag[l];
      end
      has_root      = (dv_ctl[NB].kind == KIND_ONE) || (dv_ctl[NB].kind == KIND_TWO);
      out_kind_in   = dv_ctl[NB].kind;
      out_first_in  = has_root ? sat_val[0] : '0;
      out_second_in = has_root ? sat_val[1] : '0;
      out_ovf_in    = has_root && (|sat_over);
      out_valid_in  = (dv_ctl[NB].valid && adv) || (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ctl[NB].valid && adv) begin
         out_kind_ff   <= out_kind_in;
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_ovf_ff    <= out_ovf_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.root_kind   = out_kind_ff;
   assign rsp_bus.root_first  = signed'(out_first_ff);
   assign rsp_bus.root_second = signed'(out_second_ff);
   assign rsp_bus.overflow    = out_ovf_ff;

   // checks
   `QRS_ASSERT_SAME(a_empty_kind_zero, rsp_bus.valid && (rsp_bus.root_kind == KIND_NONE || rsp_bus.root_kind == KIND_INF), rsp_bus.root_first == '0 && rsp_bus.root_second == '0 && !rsp_bus.overflow, "no-root result carries nonzero fields")
   `QRS_ASSERT_SAME(a_single_equal, rsp_bus.valid && rsp_bus.root_kind == KIND_ONE, rsp_bus.root_first == rsp_bus.root_second, "single root lanes differ")
   `QRS_ASSERT_SAME(a_ovf_at_limit, rsp_bus.valid && rsp_bus.overflow, out_first_ff == SAT_MAX || out_first_ff == SAT_MIN || out_second_ff == SAT_MAX || out_second_ff == SAT_MIN, "overflow without a clamped root")
   `QRS_ASSERT_SAME(a_full_blocks_input, dv_ctl[NB].valid && rsp_bus.valid && !rsp_bus.ready, !req_bus.ready, "input taken while chain is full")
   `QRS_ASSERT_NEXT(a_last_lands, dv_ctl[NB].valid && adv, rsp_bus.valid, "finished result lost at output")

endmodule
